// ===== hw/rtl/cot_pkg.sv =====
`default_nettype none

package cot_pkg;

	localparam int ENTRIES  = 32;
	localparam int PRESCALE = 10;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int POS_W = 20;

	typedef logic signed [POS_W-1:0] pos_t;

	// command codes
	localparam logic [1:0] CMD_ADD     = 2'd0;
	localparam logic [1:0] CMD_PULSE   = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;
	localparam logic [1:0] CMD_RELEASE = 2'd3;

	// result status codes
	localparam logic [2:0] STS_ADDED     = 3'd0;
	localparam logic [2:0] STS_RANGE     = 3'd1;
	localparam logic [2:0] STS_OVERFLOW  = 3'd2;
	localparam logic [2:0] STS_COUNTED   = 3'd3;
	localparam logic [2:0] STS_PROCESSED = 3'd4;
	localparam logic [2:0] STS_DONE      = 3'd5;

	// register indexes
	localparam logic [2:0] REG_ADVANCE_STEP  = 3'd0;
	localparam logic [2:0] REG_DETECT_LINE   = 3'd1;
	localparam logic [2:0] REG_CAPTURE_LINE  = 3'd2;
	localparam logic [2:0] REG_LOST_LINE     = 3'd3;
	localparam logic [2:0] REG_ACROSS_MAX    = 3'd4;
	localparam logic [2:0] REG_ACROSS_MIN    = 3'd5;
	localparam logic [2:0] REG_ACROSS_OFFSET = 3'd6;
	localparam logic [2:0] REG_MODE_BITS     = 3'd7;

	// register reset values
	localparam logic [11:0] ADVANCE_STEP_RST  = 12'd171;
	localparam pos_t        DETECT_LINE_RST   = -20'sd167680;
	localparam pos_t        CAPTURE_LINE_RST  = -20'sd74240;
	localparam pos_t        LOST_LINE_RST     = 20'sd71680;
	localparam pos_t        ACROSS_MAX_RST    = 20'sd35840;
	localparam pos_t        ACROSS_MIN_RST    = -20'sd35840;
	localparam pos_t        ACROSS_OFFSET_RST = -20'sd56064;
	localparam logic [1:0]  MODE_BITS_RST     = 2'd2;

	typedef struct packed {
		pos_t a;
		pos_t b;
		pos_t c;
		pos_t d;
	} alu_req_t;

	typedef struct packed {
		pos_t sum;
		logic gt_c;
		logic gt_d;
	} alu_rsp_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		pos_t             wr_data;
		logic             set_en;
		logic             clr_en;
		logic [IDX_W-1:0] clr_idx;
		logic [IDX_W-1:0] rd_addr;
	} tbl_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/conveyor_object_tracker_core.sv =====
// Add passes DISPATCH, RNG_HI, RNG_LO, ADD_AC and ADD_AL, ending early on a range or overflow fault;
// clear, release and counted pulse end in DISPATCH; a processed pulse goes DISPATCH, WALK, PICK.
// One item at a time: the walk of the object table goes one entry per cycle through the shared
// adder; start may be raised again in the done cycle.
// Results show for exactly one cycle with done; the receiver cannot stall.
// Reset (arst_n low) empties the table and clears pointers, counters and the pending pick.
`default_nettype none

module conveyor_object_tracker_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          cmd,
	input  logic signed [19:0]  cam_x,
	input  logic signed [19:0]  cam_y,
	input  logic [4:0]          entry_sel,
	input  logic                move_blocked,
	input  logic                robot_busy,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [19:0]         wr_data,
	output logic                done,
	output logic [2:0]          status,
	output logic                ready_request,
	output logic signed [19:0]  ready_across,
	output logic [5:0]          lost_now,
	output logic [15:0]         lost_total,
	output logic                current_valid,
	output logic [4:0]          current_index,
	output logic                pick_latched,
	output logic                pending_valid,
	output logic [4:0]          pending_index
);
	import cot_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_RNG_HI   = 3'd2;
	localparam logic [2:0] S_RNG_LO   = 3'd3;
	localparam logic [2:0] S_ADD_AC   = 3'd4;
	localparam logic [2:0] S_ADD_AL   = 3'd5;
	localparam logic [2:0] S_WALK     = 3'd6;
	localparam logic [2:0] S_PICK     = 3'd7;

	logic [2:0] st_q;

	// captured beat
	logic [1:0]  cmd_q;
	pos_t        cam_x_q;
	pos_t        cam_y_q;
	logic [4:0]  sel_q;
	logic        blocked_q;
	logic        robot_busy_q;

	// configuration
	logic [11:0] advance_step_q;
	pos_t        detect_line_q;
	pos_t        capture_line_q;
	pos_t        lost_line_q;
	pos_t        across_max_q;
	pos_t        across_min_q;
	pos_t        across_offset_q;
	logic [1:0]  mode_bits_q;

	// tracker state
	logic [IDX_W-1:0] write_ptr_q;
	logic [7:0]       tick_div_q;
	logic [15:0]      lost_count_q;
	logic             cur_valid_q;
	logic [IDX_W-1:0] cur_index_q;
	logic             pend_valid_q;
	logic [IDX_W-1:0] pend_index_q;

	// walk
	logic [CNT_W-1:0] walk_k_q;
	logic             walk_vld_s1;
	logic [IDX_W-1:0] walk_k_s1;
	logic             found_q;
	logic [IDX_W-1:0] best_q;
	pos_t             best_pos_q;
	logic [CNT_W-1:0] lost_now_q;

	// result
	logic        done_q;
	logic [2:0]  status_q;
	logic        ready_q;
	pos_t        ready_across_q;
	logic        latched_q;

	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;
	tbl_ctl_t         tbl_ctl;
	pos_t             tbl_rd_data;
	logic [ENTRIES-1:0] tbl_valid;

	logic             auto_on;
	logic             cam_on;
	logic             sel_ok;
	logic             any_valid;
	logic             walk_hit;
	logic [7:0]       tick_next;

	assign auto_on   = mode_bits_q[0];
	assign cam_on    = mode_bits_q[1];
	assign sel_ok    = (32'(sel_q) < ENTRIES);
	assign any_valid = |tbl_valid;
	assign walk_hit  = walk_vld_s1 && tbl_valid[walk_k_s1];
	assign tick_next = tick_div_q + 8'd1;

	cot_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	cot_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.rd_data (tbl_rd_data),
		.valid   (tbl_valid)
	);

	always_comb begin
		alu_req.a = cam_y_q;
		alu_req.b = '0;
		alu_req.c = across_max_q;
		alu_req.d = best_pos_q;
		unique case (st_q)
			S_RNG_LO: begin
				alu_req.a = across_min_q;
				alu_req.c = cam_y_q;
			end
			S_ADD_AC: begin
				alu_req.b = across_offset_q;
			end
			S_ADD_AL: begin
				alu_req.a = cam_x_q;
				alu_req.b = detect_line_q;
			end
			S_WALK: begin
				alu_req.a = tbl_rd_data;
				alu_req.b = $signed({{(POS_W-12){1'b0}}, advance_step_q});
				alu_req.c = lost_line_q;
			end
			S_PICK: begin
				alu_req.a = best_pos_q;
				alu_req.c = capture_line_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		tbl_ctl.rd_addr = walk_k_q[IDX_W-1:0];
		tbl_ctl.wr_data = alu_rsp.sum;
		tbl_ctl.set_en  = (st_q == S_ADD_AL);
		if (st_q == S_ADD_AL) begin
			tbl_ctl.wr_en   = 1'b1;
			tbl_ctl.wr_addr = write_ptr_q;
		end else begin
			tbl_ctl.wr_en   = (st_q == S_WALK) && walk_hit;
			tbl_ctl.wr_addr = walk_k_s1;
		end
		if (st_q == S_DISPATCH) begin
			tbl_ctl.clr_en  = (cmd_q == CMD_CLEAR) && sel_ok;
			tbl_ctl.clr_idx = IDX_W'(sel_q);
		end else begin
			// drop entries that passed the lost line
			tbl_ctl.clr_en  = (st_q == S_WALK) && walk_hit && alu_rsp.gt_c;
			tbl_ctl.clr_idx = walk_k_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start) begin
			cmd_q        <= cmd;
			cam_x_q      <= cam_x;
			cam_y_q      <= cam_y;
			sel_q        <= entry_sel;
			blocked_q    <= move_blocked;
			robot_busy_q <= robot_busy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			advance_step_q  <= ADVANCE_STEP_RST;
			detect_line_q   <= DETECT_LINE_RST;
			capture_line_q  <= CAPTURE_LINE_RST;
			lost_line_q     <= LOST_LINE_RST;
			across_max_q    <= ACROSS_MAX_RST;
			across_min_q    <= ACROSS_MIN_RST;
			across_offset_q <= ACROSS_OFFSET_RST;
			mode_bits_q     <= MODE_BITS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ADVANCE_STEP:  advance_step_q  <= wr_data[11:0];
				REG_DETECT_LINE:   detect_line_q   <= wr_data;
				REG_CAPTURE_LINE:  capture_line_q  <= wr_data;
				REG_LOST_LINE:     lost_line_q     <= wr_data;
				REG_ACROSS_MAX:    across_max_q    <= wr_data;
				REG_ACROSS_MIN:    across_min_q    <= wr_data;
				REG_ACROSS_OFFSET: across_offset_q <= wr_data;
				REG_MODE_BITS:     mode_bits_q     <= wr_data[1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= S_IDLE;
			write_ptr_q    <= '0;
			tick_div_q     <= '0;
			lost_count_q   <= '0;
			cur_valid_q    <= 1'b0;
			cur_index_q    <= '0;
			pend_valid_q   <= 1'b0;
			pend_index_q   <= '0;
			walk_k_q       <= '0;
			walk_vld_s1    <= 1'b0;
			walk_k_s1      <= '0;
			found_q        <= 1'b0;
			best_q         <= '0;
			best_pos_q     <= '0;
			lost_now_q     <= '0;
			done_q         <= 1'b0;
			status_q       <= STS_DONE;
			ready_q        <= 1'b0;
			ready_across_q <= '0;
			latched_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						st_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					ready_q        <= 1'b0;
					ready_across_q <= '0;
					lost_now_q     <= '0;
					latched_q      <= 1'b0;
					walk_vld_s1    <= 1'b0;
					unique case (cmd_q)
						CMD_ADD: begin
							st_q <= S_RNG_HI;
						end
						CMD_PULSE: begin
							if (tick_next < 8'(PRESCALE)) begin
								tick_div_q <= tick_next;
								status_q   <= STS_COUNTED;
								done_q     <= 1'b1;
								st_q       <= S_IDLE;
							end else begin
								tick_div_q <= '0;
								walk_k_q   <= '0;
								found_q    <= 1'b0;
								st_q       <= S_WALK;
							end
						end
						CMD_CLEAR: begin
							status_q <= STS_DONE;
							done_q   <= 1'b1;
							st_q     <= S_IDLE;
						end
						CMD_RELEASE: begin
							pend_valid_q <= 1'b0;
							status_q     <= STS_DONE;
							done_q       <= 1'b1;
							st_q         <= S_IDLE;
						end
						default: begin
						end
					endcase
				end
				S_RNG_HI: begin
					if (alu_rsp.gt_c) begin
						status_q <= STS_RANGE;
						done_q   <= 1'b1;
						st_q     <= S_IDLE;
					end else begin
						st_q <= S_RNG_LO;
					end
				end
				S_RNG_LO: begin
					if (alu_rsp.gt_c) begin
						status_q <= STS_RANGE;
						done_q   <= 1'b1;
						st_q     <= S_IDLE;
					end else if (tbl_valid[write_ptr_q]) begin
						status_q <= STS_OVERFLOW;
						done_q   <= 1'b1;
						st_q     <= S_IDLE;
					end else begin
						st_q <= S_ADD_AC;
					end
				end
				S_ADD_AC: begin
					// first object on an empty belt: ask for the ready move
					if (!any_valid && auto_on && !blocked_q) begin
						ready_q        <= 1'b1;
						ready_across_q <= alu_rsp.sum;
					end
					st_q <= S_ADD_AL;
				end
				S_ADD_AL: begin
					write_ptr_q <= (write_ptr_q == IDX_W'(ENTRIES - 1)) ? '0 : write_ptr_q + 1'b1;
					status_q    <= STS_ADDED;
					done_q      <= 1'b1;
					st_q        <= S_IDLE;
				end
				S_WALK: begin
					if (walk_k_q < CNT_W'(ENTRIES)) begin
						walk_k_q <= walk_k_q + 1'b1;
					end
					walk_vld_s1 <= (walk_k_q < CNT_W'(ENTRIES));
					walk_k_s1   <= walk_k_q[IDX_W-1:0];
					if (walk_hit) begin
						if (alu_rsp.gt_c) begin
							lost_count_q <= lost_count_q + 16'd1;
							lost_now_q   <= lost_now_q + 1'b1;
						end else if (!found_q || alu_rsp.gt_d) begin
							// strict compare keeps the lowest index on a tie
							found_q    <= 1'b1;
							best_q     <= walk_k_s1;
							best_pos_q <= alu_rsp.sum;
						end
					end
					if (walk_vld_s1 && walk_k_s1 == IDX_W'(ENTRIES - 1)) begin
						st_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (found_q && alu_rsp.gt_c && auto_on && cam_on && !robot_busy_q &&
					    !pend_valid_q) begin
						pend_valid_q <= 1'b1;
						pend_index_q <= best_q;
						latched_q    <= 1'b1;
					end
					cur_valid_q <= found_q;
					if (found_q) begin
						cur_index_q <= best_q;
					end
					status_q <= STS_PROCESSED;
					done_q   <= 1'b1;
					st_q     <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (st_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign ready_request = ready_q;
	assign ready_across  = ready_across_q;
	assign lost_now      = 6'(lost_now_q);
	assign lost_total    = lost_count_q;
	assign current_valid = cur_valid_q;
	assign current_index = 5'(cur_index_q);
	assign pick_latched  = latched_q;
	assign pending_valid = pend_valid_q;
	assign pending_index = 5'(pend_index_q);

endmodule

`default_nettype wire

// ===== hw/rtl/cot_alu.sv =====
`default_nettype none

module cot_alu (
	input  cot_pkg::alu_req_t req,
	output cot_pkg::alu_rsp_t rsp
);
	import cot_pkg::*;

	logic signed [POS_W:0] sum_wide;
	pos_t                  sum_sat;

	assign sum_wide = {req.a[POS_W-1], req.a} + {req.b[POS_W-1], req.b};

	always_comb begin
		if (sum_wide[POS_W] != sum_wide[POS_W-1]) begin
			// clamp to the signed range
			sum_sat = sum_wide[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[POS_W-1:0];
		end
	end

	assign rsp.sum  = sum_sat;
	assign rsp.gt_c = (sum_sat > req.c);
	assign rsp.gt_d = (sum_sat > req.d);

endmodule

`default_nettype wire

// ===== hw/rtl/cot_table.sv =====
`default_nettype none

module cot_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cot_pkg::tbl_ctl_t            ctl,
	output cot_pkg::pos_t                rd_data,
	output logic [cot_pkg::ENTRIES-1:0]  valid
);
	import cot_pkg::*;

	pos_t               mem [ENTRIES];
	pos_t               rd_data_q;
	logic [ENTRIES-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
		rd_data_q <= mem[ctl.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ctl.set_en) begin
				valid_q[ctl.wr_addr] <= 1'b1;
			end
			if (ctl.clr_en) begin
				valid_q[ctl.clr_idx] <= 1'b0;
			end
		end
	end

	assign rd_data = rd_data_q;
	assign valid   = valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cot_checker.sv =====
`default_nettype none

module cot_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [2:0]          status,
	input logic                ready_request,
	input logic [5:0]          lost_now,
	input logic                current_valid,
	input logic [4:0]          current_index,
	input logic                pick_latched,
	input logic                pending_valid,
	input logic [4:0]          pending_index
);
	import cot_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not make the block busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_latch_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		done && pick_latched |-> pending_valid && current_valid &&
			pending_index == current_index && status == STS_PROCESSED)
		else $error("latched pick does not match the current entry");

	a_ready_on_add: assert property (@(posedge clk) disable iff (!arst_n)
		done && ready_request |-> status == STS_ADDED)
		else $error("ready move requested outside an add");

	a_lost_on_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STS_PROCESSED |-> lost_now == 6'd0 && !pick_latched)
		else $error("drop count or latch outside a processed pulse");

endmodule

bind conveyor_object_tracker_core cot_checker u_cot_checker (.*);

`default_nettype wire

// ===== tb/conveyor_object_tracker_core_tb.sv =====
`default_nettype none

module conveyor_object_tracker_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import cot_pkg::*;

	localparam int          CYCLE_LIMIT  = 500000;
	localparam int          PHASE_ITEMS  = 140;
	localparam int          PHASES       = 6;
	localparam logic [2:0]  STS_ANY      = 3'd7;

	typedef struct packed {
		logic [1:0] cmd;
		pos_t       cam_x;
		pos_t       cam_y;
		logic [4:0] entry_sel;
		logic       move_blocked;
		logic       robot_busy;
	} belt_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        ready_request;
		pos_t        ready_across;
		logic [5:0]  lost_now;
		logic [15:0] lost_total;
		logic        current_valid;
		logic [4:0]  current_index;
		logic        pick_latched;
		logic        pending_valid;
		logic [4:0]  pending_index;
	} belt_rsp_t;

	typedef struct packed {
		belt_cmd_t  beat;
		logic [2:0] typed_sts;
	} script_row_t;

	typedef struct packed {
		int advance;
		int detect;
		int capture;
		int lost;
		int amax;
		int amin;
		int aoff;
		int mode;
		int idle_pct;
		int add_pct;
	} belt_setup_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	pos_t        cam_x;
	pos_t        cam_y;
	logic [4:0]  entry_sel;
	logic        move_blocked;
	logic        robot_busy;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [19:0] wr_data;
	logic        done;
	logic [2:0]  status;
	logic        ready_request;
	pos_t        ready_across;
	logic [5:0]  lost_now;
	logic [15:0] lost_total;
	logic        current_valid;
	logic [4:0]  current_index;
	logic        pick_latched;
	logic        pending_valid;
	logic [4:0]  pending_index;

	// tracker copy: table, pointers, counters and register file
	pos_t                trk_along [ENTRIES];
	pos_t                trk_across [ENTRIES];
	logic [ENTRIES-1:0]  trk_live = '0;
	int                  trk_wptr = 0;
	logic [7:0]          trk_tick = '0;
	logic [15:0]         trk_lost = '0;
	logic                trk_cur_v = 1'b0;
	logic [4:0]          trk_cur_i = '0;
	logic                trk_pend_v = 1'b0;
	logic [4:0]          trk_pend_i = '0;

	logic [11:0] cfg_advance = ADVANCE_STEP_RST;
	pos_t        cfg_detect = DETECT_LINE_RST;
	pos_t        cfg_capture = CAPTURE_LINE_RST;
	pos_t        cfg_lost = LOST_LINE_RST;
	pos_t        cfg_across_max = ACROSS_MAX_RST;
	pos_t        cfg_across_min = ACROSS_MIN_RST;
	pos_t        cfg_across_off = ACROSS_OFFSET_RST;
	logic [1:0]  cfg_mode = MODE_BITS_RST;

	belt_rsp_t due_results [$];
	int        err_cnt = 0;
	int        cycles = 0;

	script_row_t script [23] = '{
		'{'{CMD_RELEASE, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_DONE},
		'{'{CMD_CLEAR, 20'sd0, 20'sd0, 5'd31, 1'b0, 1'b0}, STS_DONE},
		'{'{CMD_PULSE, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b1}, STS_COUNTED},
		'{'{CMD_ADD, 20'sd0, 20'sd35841, 5'd0, 1'b0, 1'b0}, STS_RANGE},
		'{'{CMD_ADD, 20'sd0, -20'sd35841, 5'd0, 1'b0, 1'b0}, STS_RANGE},
		'{'{CMD_ADD, 20'h80000, 20'sd35840, 5'd0, 1'b0, 1'b0}, STS_ADDED},
		'{'{CMD_ADD, 20'h7FFFF, -20'sd35840, 5'd0, 1'b0, 1'b0}, STS_ADDED},
		'{'{CMD_ADD, 20'h7FFFF, 20'h7FFFF, 5'd31, 1'b1, 1'b1}, STS_RANGE},
		'{'{CMD_ADD, 20'h80000, 20'h80000, 5'd0, 1'b0, 1'b0}, STS_RANGE},
		'{'{CMD_PULSE, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_COUNTED},
		'{'{CMD_PULSE, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_COUNTED},
		'{'{CMD_PULSE, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_COUNTED},
		'{'{CMD_PULSE, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_COUNTED},
		'{'{CMD_PULSE, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_COUNTED},
		'{'{CMD_PULSE, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_COUNTED},
		'{'{CMD_PULSE, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_COUNTED},
		'{'{CMD_PULSE, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_COUNTED},
		'{'{CMD_PULSE, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_PROCESSED},
		'{'{CMD_ADD, -20'sd1000, 20'sd0, 5'd31, 1'b1, 1'b1}, STS_ADDED},
		'{'{CMD_CLEAR, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_DONE},
		'{'{CMD_RELEASE, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_DONE},
		'{'{CMD_CLEAR, 20'sd0, 20'sd0, 5'd2, 1'b0, 1'b0}, STS_DONE},
		'{'{CMD_ADD, 20'sd0, 20'sd0, 5'd0, 1'b0, 1'b0}, STS_ADDED}
	};

	// advance, detect, capture, lost, amax, amin, aoff, mode, idle %, add %
	belt_setup_t setups [PHASES] = '{
		'{4095, 0, 20000, 60000, 35840, -35840, 0, 3, 0, 25},
		'{2000, -30000, 0, 40000, 100000, -100000, 524287, 3, 56, 25},
		'{0, 0, -1, 0, 524287, -524288, -524288, 1, 0, 30},
		'{4095, 524287, 524286, 500000, 0, 0, 0, 0, 33, 60},
		'{3000, -167680, -74240, 71680, 35840, -35840, -56064, 2, 56, 20},
		'{4095, -524288, -524288, 524287, 524287, -524288, 524287, 3, 0, 20}
	};

	conveyor_object_tracker_core u_dut (.*);

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	function automatic pos_t sat_pos(input int v);
		if (v > 524287)
			return 20'h7FFFF;
		if (v < -524288)
			return 20'h80000;
		return pos_t'(v);
	endfunction

	function automatic belt_rsp_t track_step(input belt_cmd_t b);
		belt_rsp_t r;
		logic      found;
		int        best;
		pos_t      best_pos;
		r = '0;
		r.status = STS_DONE;
		case (b.cmd)
			CMD_ADD: begin
				if (b.cam_y > cfg_across_max || b.cam_y < cfg_across_min) begin
					r.status = STS_RANGE;
				end else if (trk_live[trk_wptr]) begin
					r.status = STS_OVERFLOW;
				end else begin
					trk_across[trk_wptr] = sat_pos(int'(b.cam_y) + int'(cfg_across_off));
					trk_along[trk_wptr] = sat_pos(int'(b.cam_x) + int'(cfg_detect));
					// ready move only into an empty table
					if (trk_live == '0 && cfg_mode[0] && !b.move_blocked) begin
						r.ready_request = 1'b1;
						r.ready_across = trk_across[trk_wptr];
					end
					trk_live[trk_wptr] = 1'b1;
					trk_wptr = (trk_wptr == ENTRIES - 1) ? 0 : trk_wptr + 1;
					r.status = STS_ADDED;
				end
			end
			CMD_PULSE: begin
				trk_tick = trk_tick + 8'd1;
				if (trk_tick < PRESCALE) begin
					r.status = STS_COUNTED;
				end else begin
					trk_tick = '0;
					found = 1'b0;
					best = 0;
					best_pos = '0;
					for (int k = 0; k < ENTRIES; k++) begin
						if (trk_live[k]) begin
							trk_along[k] = sat_pos(int'(trk_along[k]) + int'(cfg_advance));
							if (trk_along[k] > cfg_lost) begin
								trk_live[k] = 1'b0;
								trk_lost = trk_lost + 16'd1;
								r.lost_now = r.lost_now + 6'd1;
							end else if (!found || trk_along[k] > best_pos) begin
								found = 1'b1;
								best = k;
								best_pos = trk_along[k];
							end
						end
					end
					if (found && best_pos > cfg_capture && cfg_mode[0] && cfg_mode[1] &&
							!b.robot_busy && !trk_pend_v) begin
						trk_pend_v = 1'b1;
						trk_pend_i = 5'(best);
						r.pick_latched = 1'b1;
					end
					trk_cur_v = found;
					if (found)
						trk_cur_i = 5'(best);
					r.status = STS_PROCESSED;
				end
			end
			CMD_CLEAR: begin
				if (int'(b.entry_sel) < ENTRIES)
					trk_live[b.entry_sel] = 1'b0;
			end
			CMD_RELEASE: begin
				trk_pend_v = 1'b0;
			end
		endcase
		r.lost_total = trk_lost;
		r.current_valid = trk_cur_v;
		r.current_index = trk_cur_i;
		r.pending_valid = trk_pend_v;
		r.pending_index = trk_pend_i;
		return r;
	endfunction

	function automatic belt_cmd_t roll_beat(input int add_pct);
		belt_cmd_t b;
		int        pick;
		int        lo;
		int        span;
		b.cam_x = pos_t'($urandom);
		b.cam_y = pos_t'($urandom);
		b.entry_sel = 5'($urandom);
		b.move_blocked = ($urandom_range(99) < 30);
		b.robot_busy = ($urandom_range(99) < 25);
		pick = $urandom_range(99);
		if (pick < add_pct)
			b.cmd = CMD_ADD;
		else if (pick < add_pct + 5)
			b.cmd = CMD_CLEAR;
		else if (pick < add_pct + 10)
			b.cmd = CMD_RELEASE;
		else
			b.cmd = CMD_PULSE;
		// place most objects so that they travel through capture and lost lines
		pick = $urandom_range(99);
		if (pick < 50) begin
			lo = int'(cfg_capture) - 40000 - int'(cfg_detect);
			span = int'(cfg_lost) - int'(cfg_capture) + 40000;
			if (span < 0)
				span = 0;
			b.cam_x = pos_t'(lo + int'($urandom_range(span)));
		end else if (pick < 70) begin
			b.cam_x = pos_t'(int'(cfg_capture) - int'(cfg_detect) + 4096 * $urandom_range(3));
		end
		pick = $urandom_range(99);
		if (pick < 40 && cfg_across_min <= cfg_across_max)
			b.cam_y = pos_t'(int'(cfg_across_min) +
				int'($urandom_range(int'(cfg_across_max) - int'(cfg_across_min))));
		else if (pick < 50)
			b.cam_y = cfg_across_max;
		else if (pick < 60)
			b.cam_y = cfg_across_min;
		else if (pick < 65)
			b.cam_y = pos_t'(int'(cfg_across_max) + 1);
		else if (pick < 70)
			b.cam_y = pos_t'(int'(cfg_across_min) - 1);
		return b;
	endfunction

	// hold start until the beat is taken, then log what the tracker must answer
	task automatic send_beat(input belt_cmd_t b, input logic [2:0] typed_sts);
		belt_rsp_t r;
		start <= 1'b1;
		cmd <= b.cmd;
		cam_x <= b.cam_x;
		cam_y <= b.cam_y;
		entry_sel <= b.entry_sel;
		move_blocked <= b.move_blocked;
		robot_busy <= b.robot_busy;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		r = track_step(b);
		if (typed_sts != STS_ANY)
			r.status = typed_sts;
		due_results.push_back(r);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= 20'(val);
		@(posedge clk);
		case (idx)
			REG_ADVANCE_STEP:  cfg_advance = 12'(val);
			REG_DETECT_LINE:   cfg_detect = pos_t'(val);
			REG_CAPTURE_LINE:  cfg_capture = pos_t'(val);
			REG_LOST_LINE:     cfg_lost = pos_t'(val);
			REG_ACROSS_MAX:    cfg_across_max = pos_t'(val);
			REG_ACROSS_MIN:    cfg_across_min = pos_t'(val);
			REG_ACROSS_OFFSET: cfg_across_off = pos_t'(val);
			REG_MODE_BITS:     cfg_mode = 2'(val);
		endcase
	endtask

	task automatic check_field(input string what, input logic [19:0] want, input logic [19:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin : result_check
		belt_rsp_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (due_results.size() == 0) begin
				$display("%0t unexpected result: expected none, actual status %0d",
					$time, status);
				err_cnt++;
			end else begin
				want = due_results.pop_front();
				check_field("status", 20'(want.status), 20'(status));
				check_field("ready_request", 20'(want.ready_request), 20'(ready_request));
				check_field("ready_across", want.ready_across, ready_across);
				check_field("lost_now", 20'(want.lost_now), 20'(lost_now));
				check_field("lost_total", 20'(want.lost_total), 20'(lost_total));
				check_field("current_valid", 20'(want.current_valid), 20'(current_valid));
				check_field("current_index", 20'(want.current_index), 20'(current_index));
				check_field("pick_latched", 20'(want.pick_latched), 20'(pick_latched));
				check_field("pending_valid", 20'(want.pending_valid), 20'(pending_valid));
				check_field("pending_index", 20'(want.pending_index), 20'(pending_index));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout, %0d results outstanding", $time, due_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		belt_cmd_t b;
		int        n;
		int        sweep_left;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_ADD;
		cam_x <= '0;
		cam_y <= '0;
		entry_sel <= '0;
		move_blocked <= 1'b0;
		robot_busy <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_ADVANCE_STEP;
		wr_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_beat(script[i].beat, script[i].typed_sts);
		start <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(REG_ADVANCE_STEP, setups[ph].advance);
			write_reg(REG_DETECT_LINE, setups[ph].detect);
			write_reg(REG_CAPTURE_LINE, setups[ph].capture);
			write_reg(REG_LOST_LINE, setups[ph].lost);
			write_reg(REG_ACROSS_MAX, setups[ph].amax);
			write_reg(REG_ACROSS_MIN, setups[ph].amin);
			write_reg(REG_ACROSS_OFFSET, setups[ph].aoff);
			write_reg(REG_MODE_BITS, setups[ph].mode);
			wr_en <= 1'b0;
			n = 0;
			sweep_left = 0;
			while (n < PHASE_ITEMS) begin
				// now and then empty the whole table so ready moves can happen
				if (sweep_left == 0 && $urandom_range(99) == 0)
					sweep_left = ENTRIES;
				if (sweep_left != 0) begin
					b = '0;
					b.cmd = CMD_CLEAR;
					b.entry_sel = 5'(ENTRIES - sweep_left);
					sweep_left--;
				end else begin
					b = roll_beat(setups[ph].add_pct);
				end
				send_beat(b, STS_ANY);
				n++;
				if ($urandom_range(99) < setups[ph].idle_pct) begin
					start <= 1'b0;
					repeat ($urandom_range(1, ($urandom_range(99) < 80) ? 4 : 40))
						@(posedge clk);
				end
			end
			start <= 1'b0;
			while (due_results.size() != 0)
				@(posedge clk);
		end

		repeat (60) @(posedge clk);
		if (err_cnt == 0 && due_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
